// ===== rtl/atomic_sequence_scanner_unit_macros.svh =====
// Assertion macros shared by the scanner RTL.
`ifndef ATOMIC_SEQUENCE_SCANNER_UNIT_MACROS_SVH
`define ATOMIC_SEQUENCE_SCANNER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that an expression holds at every clock edge outside reset.
`define ATSCAN_ASSERT(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("scanner assertion failed");

// Check that a condition implies a consequence in the following cycle.
`define ATSCAN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("scanner assertion failed");

`else

`define ATSCAN_ASSERT(lbl, clk, rstn, expr)
`define ATSCAN_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/atscan_pkg.sv =====
package atscan_pkg;

  localparam int unsigned MAX_TARGETS = 8;
  localparam int unsigned SCAN_WINDOW = 32;

  localparam int unsigned IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TARGETS + 1);
  localparam int unsigned SCN_W = (SCAN_WINDOW > 1) ? $clog2(SCAN_WINDOW) : 1;

  localparam logic [31:0] LARX_MASK   = 32'hfc0007fe;
  localparam logic [31:0] STCX_MASK   = 32'hfc0007ff;
  localparam logic [31:0] OPCODE_MASK = 32'hfc000000;
  localparam logic [31:0] BC_OPCODE   = 32'h40000000;

  localparam logic [31:0] LBARX = 32'h7c000068;
  localparam logic [31:0] LHARX = 32'h7c0000e8;
  localparam logic [31:0] LWARX = 32'h7c000028;
  localparam logic [31:0] LDARX = 32'h7c0000a8;
  localparam logic [31:0] LQARX = 32'h7c000228;

  localparam logic [31:0] STBCX = 32'h7c00056d;
  localparam logic [31:0] STHCX = 32'h7c0005ad;
  localparam logic [31:0] STWCX = 32'h7c00012d;
  localparam logic [31:0] STDCX = 32'h7c0001ad;
  localparam logic [31:0] STQCX = 32'h7c00016d;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_ATOMIC = 2'd1,
    ST_TOO_MANY   = 2'd2,
    ST_NO_STCX    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WALK
  } ctl_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic    open;
    logic    add;
    logic    close;
    logic    advance;
    logic    fail;
    status_e fail_status;
    logic    walk_step;
  } atscan_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_larx;
    logic is_stcx;
    logic is_bc;
    logic table_full;
    logic window_end;
    logic walk_last;
    logic walk_keep;
    logic out_free;
  } atscan_sts_t;

  function automatic logic word_is_larx(logic [31:0] w);
    logic [31:0] b;
    b = w & LARX_MASK;
    return b inside {LBARX, LHARX, LWARX, LDARX, LQARX};
  endfunction

  function automatic logic word_is_stcx(logic [31:0] w);
    logic [31:0] b;
    b = w & STCX_MASK;
    return b inside {STBCX, STHCX, STWCX, STDCX, STQCX};
  endfunction

  function automatic logic word_is_bc(logic [31:0] w);
    return (w & OPCODE_MASK) == BC_OPCODE;
  endfunction

  function automatic logic [63:0] bc_target(logic [31:0] w, logic [63:0] addr);
    logic [63:0] disp;
    disp = {{48{w[15]}}, w[15:2], 2'b00};
    return w[1] ? disp : (addr + disp);
  endfunction

endpackage

// ===== rtl/atscan_ctrl.sv =====
`include "atomic_sequence_scanner_unit_macros.svh"

module atscan_ctrl
  import atscan_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  atscan_sts_t sts_i,
  output atscan_cmd_t cmd_o
);

  ctl_state_e state_q, state_d;
  logic       in_fire;

  assign in_ready_o = sts_i.out_free && (state_q != S_WALK);
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && sts_i.is_larx) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (in_fire) begin
          if (sts_i.is_stcx) begin
            state_d = S_WALK;
          end else if (sts_i.is_bc && sts_i.table_full) begin
            state_d = S_IDLE;
          end else if (sts_i.window_end) begin
            state_d = S_IDLE;
          end
        end
      end
      S_WALK: begin
        if (sts_i.out_free && sts_i.walk_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o = '0;
    cmd_o.fail_status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (sts_i.is_larx) begin
            cmd_o.open = 1'b1;
          end else begin
            cmd_o.fail        = 1'b1;
            cmd_o.fail_status = ST_NOT_ATOMIC;
          end
        end
      end
      S_SCAN: begin
        if (in_fire) begin
          if (sts_i.is_stcx) begin
            cmd_o.close = 1'b1;
          end else if (sts_i.is_bc && sts_i.table_full) begin
            cmd_o.fail        = 1'b1;
            cmd_o.fail_status = ST_TOO_MANY;
          end else begin
            cmd_o.add     = sts_i.is_bc;
            cmd_o.advance = 1'b1;
            if (sts_i.window_end) begin
              cmd_o.fail        = 1'b1;
              cmd_o.fail_status = ST_NO_STCX;
            end
          end
        end
      end
      S_WALK: begin
        cmd_o.walk_step = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  `ATSCAN_ASSERT_NEXT(a_close_walks, clk_i, rst_ni, state_q == S_SCAN && in_fire && sts_i.is_stcx, state_q == S_WALK)
  `ATSCAN_ASSERT_NEXT(a_walk_ends, clk_i, rst_ni, state_q == S_WALK && cmd_o.walk_step && sts_i.walk_last, state_q == S_IDLE)

endmodule

// ===== rtl/atscan_dpath.sv =====
`include "atomic_sequence_scanner_unit_macros.svh"

module atscan_dpath
  import atscan_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] insn_word_i,
  input  logic [63:0] insn_addr_i,
  input  atscan_cmd_t cmd_i,
  output atscan_sts_t sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [63:0] target_addr_o,
  output logic        last_o
);

  logic [63:0]      start_q, start_d;
  logic [63:0]      end_q, end_d;
  logic [SCN_W-1:0] scan_q, scan_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [63:0]      table_q [MAX_TARGETS];
  logic [MAX_TARGETS-1:0] live_q, live_d;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  status_q, status_d;
  logic [63:0] target_q, target_d;
  logic        last_q, last_d;

  logic             wr_en;
  logic [63:0]      wr_val;
  logic [IDX_W-1:0] wr_idx;
  logic [63:0]      rd_val;
  logic             in_region;
  logic             out_free;

  assign out_free  = !out_valid_q || out_ready_i;
  assign wr_idx    = count_q[IDX_W-1:0];
  assign wr_en     = cmd_i.close || cmd_i.add;
  assign wr_val    = cmd_i.close ? (insn_addr_i + 64'd4) : bc_target(insn_word_i, insn_addr_i);
  assign rd_val    = table_q[idx_q];
  assign in_region = (rd_val >= start_q) && (rd_val < end_q);

  always_comb begin
    sts_o            = '0;
    sts_o.is_larx    = word_is_larx(insn_word_i);
    sts_o.is_stcx    = word_is_stcx(insn_word_i);
    sts_o.is_bc      = word_is_bc(insn_word_i);
    sts_o.table_full = count_q >= CNT_W'(MAX_TARGETS - 1);
    sts_o.window_end = scan_q == SCN_W'(SCAN_WINDOW - 1);
    sts_o.walk_last  = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
    sts_o.walk_keep  = live_q[idx_q] && !in_region;
    sts_o.out_free   = out_free;
  end

  // Control registers.
  always_comb begin
    scan_d  = scan_q;
    count_d = count_q;
    idx_d   = idx_q;
    live_d  = live_q;
    if (cmd_i.open) begin
      scan_d  = SCN_W'(1);
      count_d = '0;
    end
    if (cmd_i.advance) scan_d = scan_q + SCN_W'(1);
    if (wr_en) begin
      // Kill earlier copies of the new target.
      for (int j = 0; j < MAX_TARGETS; j++) begin
        if (CNT_W'(j) < count_q && table_q[j] == wr_val) live_d[j] = 1'b0;
      end
      live_d[wr_idx] = 1'b1;
      count_d        = count_q + CNT_W'(1);
    end
    if (cmd_i.close) idx_d = '0;
    if (cmd_i.walk_step) idx_d = idx_q + IDX_W'(1);
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    target_d    = target_q;
    last_d      = last_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_i.fail) begin
      out_valid_d = 1'b1;
      status_d    = cmd_i.fail_status;
      target_d    = '0;
      last_d      = 1'b1;
    end else if (cmd_i.walk_step && sts_o.walk_keep) begin
      out_valid_d = 1'b1;
      status_d    = ST_OK;
      target_d    = rd_val;
      last_d      = sts_o.walk_last;
    end
  end

  always_comb begin
    start_d = cmd_i.open ? insn_addr_i : start_q;
    end_d   = cmd_i.close ? (insn_addr_i + 64'd4) : end_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      scan_q      <= scan_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q  <= start_d;
    end_q    <= end_d;
    status_q <= status_d;
    target_q <= target_d;
    last_q   <= last_d;
    if (wr_en) table_q[wr_idx] <= wr_val;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign target_addr_o = target_q;
  assign last_o        = last_q;

  `ATSCAN_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(MAX_TARGETS))
  `ATSCAN_ASSERT(a_end_survives, clk_i, rst_ni, !(cmd_i.walk_step && sts_o.walk_last) || sts_o.walk_keep)

endmodule

// ===== rtl/atomic_sequence_scanner_unit.sv =====
// Channel   Direction  Handshake                Payload
// in        request    in_valid_i / in_ready_o  insn_word_i, insn_addr_i
// out       result     out_valid_o / out_ready_i status_o, target_addr_o, last_o
//
// Outside a walk, one request is taken per cycle while the result register is free.
// A store-conditional starts a walk over the target table, one recorded target
// (at most MAX_TARGETS) per step through the single table read port; no request is
// taken during the walk. Reset clears the controller, counters and live bits.
// A stalled result holds the walk and blocks new requests until it is taken.

module atomic_sequence_scanner_unit
  import atscan_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] insn_word_i,
  input  logic [63:0] insn_addr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [63:0] target_addr_o,
  output logic        last_o
);

  // Command and status bundles between the sequencer and the datapath.
  atscan_cmd_t cmd;
  atscan_sts_t sts;

  // Sequencer: open, track and close a scan, then step the table walk.
  atscan_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: decode words, hold the target table, filter and emit results.
  atscan_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .insn_word_i   (insn_word_i),
    .insn_addr_i   (insn_addr_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .target_addr_o (target_addr_o),
    .last_o        (last_o)
  );

endmodule
